[rtl/core/mealy_feedback_bit_generator_unit_assert.svh]
// Assertion macros used by the bit generator sequencer (mfbg_ctrl).
`ifndef MEALY_FEEDBACK_BIT_GENERATOR_UNIT_ASSERT_SVH
`define MEALY_FEEDBACK_BIT_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MFBG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MFBG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/mfbg_pkg.sv]
// Shared constants, types and helpers of the feedback bit generator.
`timescale 1ns / 1ps

package mfbg_pkg;

	localparam int MAX_STATES  = 8;
	localparam int QUEUE_DEPTH = 64;
	localparam int MAX_OUT     = 64;

	localparam int STATE_W = 3;
	localparam int LEN_W   = 6;
	localparam int CNT_W   = $clog2(MAX_OUT + 1);
	localparam int QADDR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_BIT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NS_ZERO     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NS_ONE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_LEN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_FIRST  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_SECOND = 3'd6;

	// controller -> datapath
	typedef struct packed {
		logic start;
		logic emit_seed;
		logic pop;
		logic emit_first;
		logic emit_second;
	} mfbg_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
		logic need_second;
		logic fin;
	} mfbg_sts_t;

	function automatic logic [STATE_W-1:0] clamp_state(input logic [STATE_W-1:0] s);
		logic [STATE_W:0] lim;
		lim = (STATE_W + 1)'(MAX_STATES);
		if ({1'b0, s} >= lim)
			return STATE_W'(MAX_STATES - 1);
		return s;
	endfunction

endpackage

[rtl/core/mfbg_ctrl.sv]
// Run sequencer of the feedback bit generator.
`timescale 1ns / 1ps
`include "mealy_feedback_bit_generator_unit_assert.svh"

module mfbg_ctrl
	import mfbg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  mfbg_sts_t  sts,
	output mfbg_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SEED  = 5'b00010,
		ST_RD    = 5'b00100,
		ST_EMIT0 = 5'b01000,
		ST_EMIT1 = 5'b10000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SEED;
				end
			end
			ST_SEED: begin
				if (sts.out_free) begin
					cmd.emit_seed = 1'b1;
					state_d       = sts.fin ? ST_IDLE : ST_RD;
				end
			end
			ST_RD: begin
				cmd.pop = 1'b1;
				state_d = ST_EMIT0;
			end
			ST_EMIT0: begin
				if (sts.out_free) begin
					cmd.emit_first = 1'b1;
					if (sts.need_second)
						state_d = ST_EMIT1;
					else
						state_d = sts.fin ? ST_IDLE : ST_RD;
				end
			end
			ST_EMIT1: begin
				if (sts.out_free) begin
					cmd.emit_second = 1'b1;
					state_d         = sts.fin ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`MFBG_ASSERT_NXT(a_start_seed, state_q == ST_IDLE && in_valid, state_q == ST_SEED,
		"accepted request did not start with the seed")
	`MFBG_ASSERT_IMP(a_emit_free, cmd.emit_seed || cmd.emit_first || cmd.emit_second,
		sts.out_free, "emit while output register occupied")
	`MFBG_ASSERT_NXT(a_rd_emit, state_q == ST_RD, state_q == ST_EMIT0,
		"queue read not followed by response")
	`MFBG_ASSERT_NXT(a_second, state_q == ST_EMIT0 && sts.out_free && sts.need_second,
		state_q == ST_EMIT1, "two-bit response lost its second bit")

endmodule

[rtl/core/mfbg_dpath.sv]
// Datapath: config registers, bit queue, machine state, output register.
`timescale 1ns / 1ps

module mfbg_dpath
	import mfbg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  mfbg_cmd_t             cmd,
	output mfbg_sts_t             sts,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [LEN_W-1:0]      length,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  bit_res,
	output logic                  last
);

	logic                  first_bit_q;
	logic [STATE_W-1:0]    start_state_q;
	logic [23:0]           ns_zero_q;
	logic [23:0]           ns_one_q;
	logic [15:0]           resp_len_q;
	logic [15:0]           resp_first_q;
	logic [15:0]           resp_second_q;

	logic [LEN_W-1:0]      len_q;
	logic [CNT_W-1:0]      n_q;
	logic [QADDR_W-1:0]    head_q;
	logic [QADDR_W-1:0]    tail_q;
	logic [QCNT_W-1:0]     qcnt_q;
	logic [STATE_W-1:0]    mstate_q;
	logic                  qmem_q [QUEUE_DEPTH];
	logic                  rd_bit_q;
	logic                  rd_empty_q;

	logic                  out_valid_q;
	logic                  bit_q;
	logic                  last_q;

	logic                  pop_bit;
	logic [STATE_W:0]      idx;
	logic                  two;
	logic                  r0;
	logic                  r1;
	logic [STATE_W-1:0]    nxt_state;
	logic [CNT_W-1:0]      n_inc;
	logic                  emit;
	logic                  emit_bit;
	logic                  emit_last;
	logic                  push;
	logic                  step_state;

	function automatic logic [QADDR_W-1:0] ptr_adv(input logic [QADDR_W-1:0] p);
		if (p == QADDR_W'(QUEUE_DEPTH - 1))
			return '0;
		return p + QADDR_W'(1);
	endfunction

	// table lookup for the current state and popped bit
	assign pop_bit   = rd_bit_q & ~rd_empty_q;
	assign idx       = {mstate_q, pop_bit};
	assign two       = resp_len_q[idx];
	assign r0        = resp_first_q[idx];
	assign r1        = resp_second_q[idx];
	assign nxt_state = clamp_state(pop_bit ? ns_one_q[mstate_q*3 +: 3]
	                                       : ns_zero_q[mstate_q*3 +: 3]);

	assign n_inc           = n_q + CNT_W'(1);
	assign sts.out_free    = ~out_valid_q | ~out_stall;
	assign sts.need_second = two & (n_inc < CNT_W'(MAX_OUT));
	assign sts.fin         = (n_inc >= CNT_W'(len_q)) | (n_inc >= CNT_W'(MAX_OUT));

	assign emit = cmd.emit_seed | cmd.emit_first | cmd.emit_second;

	always_comb begin
		emit_bit  = r1;
		emit_last = sts.fin;
		if (cmd.emit_seed) begin
			emit_bit = first_bit_q;
		end else if (cmd.emit_first) begin
			emit_bit  = r0;
			emit_last = sts.fin & ~sts.need_second;
		end
	end

	assign push       = emit & (qcnt_q < QCNT_W'(QUEUE_DEPTH));
	assign step_state = cmd.emit_second | (cmd.emit_first & ~sts.need_second);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_bit_q   <= 1'b0;
			start_state_q <= '0;
			ns_zero_q     <= '0;
			ns_one_q      <= '0;
			resp_len_q    <= '0;
			resp_first_q  <= '0;
			resp_second_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIRST_BIT:   first_bit_q   <= cfg_data[0];
				REG_START_STATE: start_state_q <= cfg_data[STATE_W-1:0];
				REG_NS_ZERO:     ns_zero_q     <= cfg_data[23:0];
				REG_NS_ONE:      ns_one_q      <= cfg_data[23:0];
				REG_RESP_LEN:    resp_len_q    <= cfg_data[15:0];
				REG_RESP_FIRST:  resp_first_q  <= cfg_data[15:0];
				REG_RESP_SECOND: resp_second_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// run counters, queue pointers, machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			n_q        <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			qcnt_q     <= '0;
			mstate_q   <= '0;
			rd_empty_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				len_q    <= length;
				n_q      <= '0;
				head_q   <= '0;
				tail_q   <= '0;
				qcnt_q   <= '0;
				mstate_q <= clamp_state(start_state_q);
			end
			if (emit) begin
				n_q <= n_inc;
			end
			if (push) begin
				tail_q <= ptr_adv(tail_q);
				qcnt_q <= qcnt_q + QCNT_W'(1);
			end
			if (cmd.pop) begin
				rd_empty_q <= (qcnt_q == '0);
				if (qcnt_q != '0) begin
					head_q <= ptr_adv(head_q);
					qcnt_q <= qcnt_q - QCNT_W'(1);
				end
			end
			if (step_state) begin
				mstate_q <= nxt_state;
			end
		end
	end

	// bit queue storage, registered read
	always_ff @(posedge clk) begin
		if (push) begin
			qmem_q[tail_q] <= emit_bit;
		end
		if (cmd.pop) begin
			rd_bit_q <= qmem_q[head_q];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			bit_q  <= emit_bit;
			last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign bit_res   = bit_q;
	assign last      = last_q;

endmodule

[rtl/core/mealy_feedback_bit_generator_unit.sv]
// Top level of the self-feeding table-driven bit generator.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall / length): one word requests a run of
//   length bits. in_stall is high while a run is in progress.
//   Output channel (out_valid / out_stall / bit_res / last): one word per
//   generated bit, last set on the final bit of the run. A run of length L
//   yields L or L+1 words (only the seed when L is 0 or 1).
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready
//   is always high; write only while no run is in flight.
// Timing:
//   The seed bit is loaded into the output register from the seed state,
//   which follows an accepted request. Each later response passes through
//   a queue read state, needed by the registered read port of the bit
//   queue, and then an emit state for each response bit. A new request is
//   taken the cycle after the last bit is loaded into the output register.
// Reset:
//   arst_n clears all config registers, the machine state and the output
//   valid. The queue is restarted at every run, so it needs no clearing.
// Stall:
//   out_stall freezes the output word; the sequencer waits with it.

module mealy_feedback_bit_generator_unit
	import mfbg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [LEN_W-1:0]      length,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  bit_res,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	mfbg_cmd_t cmd;
	mfbg_sts_t sts;

	// registers are plain flops
	assign cfg_ready = 1'b1;

	// sequencer: seed, then read / respond until the run is complete
	mfbg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// tables, queue, counters and output word
	mfbg_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.length    (length),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bit_res   (bit_res),
		.last      (last)
	);

endmodule

[test/mealy_feedback_bit_generator_unit_test.sv]
// Self-checking testbench for the feedback bit generator: directed plan, then random runs.
`timescale 1ns / 1ps

module mealy_feedback_bit_generator_unit_test;
	import mfbg_pkg::*;

	// no such register; a write there must leave every table untouched
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	// cycles with no word moving on any channel before the run is declared hung
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_PHASES = 6;
	localparam int RUNS_PER_PHASE = 22;

	typedef enum logic {ROW_WRITE, ROW_RUN} row_kind_t;

	// One step of the stimulus plan. A run row may carry its expected answer
	// typed in (every bit equal to typed_bit, typed_n words); otherwise the
	// run is checked against the generator model below.
	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic [LEN_W-1:0]       len;
		logic                   typed;
		logic                   typed_bit;
		logic [6:0]             typed_n;
	} plan_row_t;

	typedef struct packed {
		logic bit_res;
		logic last;
	} gen_bit_t;

	localparam int PLAN_ROWS = 33;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		// reset tables: seed 0, every step answers a single 0
		'{ROW_RUN,   REG_FIRST_BIT,   24'h000000, 6'd0,  1'b1, 1'b0, 7'd1},
		'{ROW_RUN,   REG_FIRST_BIT,   24'h000000, 6'd1,  1'b1, 1'b0, 7'd1},
		'{ROW_RUN,   REG_FIRST_BIT,   24'h000000, 6'd2,  1'b1, 1'b0, 7'd2},
		'{ROW_RUN,   REG_FIRST_BIT,   24'h000000, 6'd63, 1'b1, 1'b0, 7'd63},
		// seed 1, every answer two 1s: runs overshoot even lengths by one
		'{ROW_WRITE, REG_FIRST_BIT,   24'h000001, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_WRITE, REG_RESP_LEN,    24'h00FFFF, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_WRITE, REG_RESP_FIRST,  24'h00FFFF, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_WRITE, REG_RESP_SECOND, 24'h00FFFF, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_RUN,   REG_FIRST_BIT,   24'h000000, 6'd0,  1'b1, 1'b1, 7'd1},
		'{ROW_RUN,   REG_FIRST_BIT,   24'h000000, 6'd2,  1'b1, 1'b1, 7'd3},
		'{ROW_RUN,   REG_FIRST_BIT,   24'h000000, 6'd3,  1'b1, 1'b1, 7'd3},
		'{ROW_RUN,   REG_FIRST_BIT,   24'h000000, 6'd62, 1'b1, 1'b1, 7'd63},
		// state 0 answers one bit, all others two, every edge leads to 1:
		// length 63 ends on a pair and fills all 64 slots
		'{ROW_WRITE, REG_RESP_LEN,    24'h00FFFC, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_WRITE, REG_NS_ZERO,     24'h249249, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_WRITE, REG_NS_ONE,      24'h249249, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_RUN,   REG_FIRST_BIT,   24'h000000, 6'd63, 1'b0, 1'b0, 7'd0},
		'{ROW_RUN,   REG_FIRST_BIT,   24'h000000, 6'd4,  1'b0, 1'b0, 7'd0},
		// top state, mixed answers
		'{ROW_WRITE, REG_START_STATE, 24'h000007, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_WRITE, REG_NS_ZERO,     24'hFFFFFF, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_WRITE, REG_NS_ONE,      24'h000000, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_WRITE, REG_RESP_LEN,    24'h00AAAA, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_WRITE, REG_RESP_FIRST,  24'h005555, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_WRITE, REG_RESP_SECOND, 24'h000F0F, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_WRITE, REG_FIRST_BIT,   24'h000000, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_RUN,   REG_FIRST_BIT,   24'h000000, 6'd63, 1'b0, 1'b0, 7'd0},
		'{ROW_RUN,   REG_FIRST_BIT,   24'h000000, 6'd17, 1'b0, 1'b0, 7'd0},
		'{ROW_RUN,   REG_FIRST_BIT,   24'h000000, 6'd1,  1'b0, 1'b0, 7'd0},
		// upper data bits beyond a register's width are dropped
		'{ROW_WRITE, REG_FIRST_BIT,   24'hFFFFFE, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_WRITE, REG_START_STATE, 24'hFFFFF8, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_RUN,   REG_FIRST_BIT,   24'h000000, 6'd40, 1'b0, 1'b0, 7'd0},
		// write to the unmapped index, then the same run again
		'{ROW_WRITE, REG_UNUSED,      24'hFFFFFF, 6'd0,  1'b0, 1'b0, 7'd0},
		'{ROW_RUN,   REG_FIRST_BIT,   24'h000000, 6'd40, 1'b0, 1'b0, 7'd0},
		'{ROW_RUN,   REG_FIRST_BIT,   24'h000000, 6'd63, 1'b0, 1'b0, 7'd0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [LEN_W-1:0]      length = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  bit_res;
	logic                  last;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	mealy_feedback_bit_generator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.length    (length),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bit_res   (bit_res),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Model copy of the config registers, updated on each accepted write word.
	logic                 gen_first_bit;
	logic [STATE_W-1:0]   gen_start_state;
	logic [23:0]          gen_next_on_zero;
	logic [23:0]          gen_next_on_one;
	logic [15:0]          gen_two_bits;
	logic [15:0]          gen_first_resp;
	logic [15:0]          gen_second_resp;
	logic [STATE_W-1:0]   gen_state;

	gen_bit_t   bits_expected[$];
	plan_row_t  runs_requested[$];
	int         mismatch_count = 0;
	int         idle_cycles = 0;
	logic       steady = 1'b0;   // phase with no idling on either side
	int         stall_left = 0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Mostly no gap, some short ones, a few long ones; none in steady phases.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic logic [STATE_W-1:0] clip_state(input logic [STATE_W-1:0] s);
		return (s >= MAX_STATES) ? STATE_W'(MAX_STATES - 1) : s;
	endfunction

	// Generator model: emits the seed, then keeps popping its own output
	// and answering from the tables until the requested length is covered.
	function automatic void generate_run(input int len);
		logic        fifo[$];
		logic        run_bits[$];
		logic        b, two, r0, r1;
		logic [23:0] tbl;
		int          idx;
		gen_bit_t    w;

		gen_state = clip_state(gen_start_state);
		run_bits = {run_bits, gen_first_bit};
		fifo = {fifo, gen_first_bit};
		while (run_bits.size() < len && run_bits.size() < MAX_OUT) begin
			b = (fifo.size() != 0) ? fifo.pop_front() : 1'b0;
			idx = int'(gen_state) * 2 + int'(b);
			two = gen_two_bits[idx];
			r0 = gen_first_resp[idx];
			r1 = gen_second_resp[idx];
			tbl = b ? gen_next_on_one : gen_next_on_zero;
			run_bits = {run_bits, r0};
			if (fifo.size() < QUEUE_DEPTH)
				fifo = {fifo, r0};
			if (two && run_bits.size() < MAX_OUT) begin
				run_bits = {run_bits, r1};
				if (fifo.size() < QUEUE_DEPTH)
					fifo = {fifo, r1};
			end
			gen_state = clip_state(tbl[int'(gen_state) * 3 +: 3]);
		end
		foreach (run_bits[k]) begin
			w.bit_res = run_bits[k];
			w.last = (k == run_bits.size() - 1);
			bits_expected = {bits_expected, w};
		end
	endfunction

	// Output stall: random bursts, shared gap profile with the sender.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			stall_left <= pick_gap();
		end
	end

	// Monitor: tracks config writes, predicts at each accepted request,
	// checks each accepted output word, and watches for a hang.
	always @(posedge clk) begin : monitor
		plan_row_t req;
		gen_bit_t  want;
		logic      moved;

		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				case (cfg_index)
					REG_FIRST_BIT:   gen_first_bit    = cfg_data[0];
					REG_START_STATE: gen_start_state  = cfg_data[STATE_W-1:0];
					REG_NS_ZERO:     gen_next_on_zero = cfg_data[23:0];
					REG_NS_ONE:      gen_next_on_one  = cfg_data[23:0];
					REG_RESP_LEN:    gen_two_bits     = cfg_data[15:0];
					REG_RESP_FIRST:  gen_first_resp   = cfg_data[15:0];
					REG_RESP_SECOND: gen_second_resp  = cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				req = runs_requested.pop_front();
				if (req.typed) begin
					for (int k = 0; k < req.typed_n; k++) begin
						want.bit_res = req.typed_bit;
						want.last = (k == req.typed_n - 1);
						bits_expected = {bits_expected, want};
					end
				end else begin
					generate_run(int'(length));
				end
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (bits_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected word bit_res=%0b last=%0b",
						bit_res, last));
				end else begin
					want = bits_expected.pop_front();
					if (bit_res !== want.bit_res)
						report_mismatch($sformatf("bit_res got %0b want %0b",
							bit_res, want.bit_res));
					if (last !== want.last)
						report_mismatch($sformatf("last got %0b want %0b",
							last, want.last));
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Request one run; valid holds through the stall until the word is taken.
	task automatic send_run(input plan_row_t row);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		runs_requested = {runs_requested, row};
		in_valid <= 1'b1;
		length <= row.len;
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	// Let every run in flight finish, then give the sequencer time to settle.
	task automatic drain_runs();
		in_valid <= 1'b0;
		do @(posedge clk); while (bits_expected.size() != 0 || runs_requested.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		plan_row_t             row;
		logic [CFG_DATA_W-1:0] data;
		int                    r;

		// model tables match the cleared registers
		gen_first_bit = 1'b0;
		gen_start_state = '0;
		gen_next_on_zero = '0;
		gen_next_on_one = '0;
		gen_two_bits = '0;
		gen_first_resp = '0;
		gen_second_resp = '0;
		gen_state = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan
		for (int i = 0; i < PLAN_ROWS; i++) begin
			row = PLAN[i];
			if (row.kind == ROW_WRITE) begin
				drain_runs();
				write_reg(row.idx, row.data);
			end else begin
				send_run(row);
			end
		end

		// random phases: fresh tables each time, extremes mixed in
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_runs();
			steady = (p % 3 == 2);
			for (int g = int'(REG_FIRST_BIT); g <= int'(REG_RESP_SECOND); g++) begin
				r = $urandom_range(0, 5);
				data = (r == 0) ? '0 : (r == 1) ? '1 : CFG_DATA_W'($urandom());
				write_reg(CFG_IDX_W'(g), data);
			end
			if (p == 3)
				write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
			for (int n = 0; n < RUNS_PER_PHASE; n++) begin
				row = '0;
				row.kind = ROW_RUN;
				r = $urandom_range(0, 99);
				if (r < 15)
					row.len = LEN_W'($urandom_range(0, 1));
				else if (r < 30)
					row.len = LEN_W'($urandom_range(62, 63));
				else
					row.len = LEN_W'($urandom_range(0, 63));
				send_run(row);
			end
		end

		drain_runs();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/mfbg_pkg.sv
rtl/core/mfbg_ctrl.sv
rtl/core/mfbg_dpath.sv
rtl/core/mealy_feedback_bit_generator_unit.sv
test/mealy_feedback_bit_generator_unit_test.sv
